FILE: rtl/cukl_pkg.sv
// ---------------------------------------------------------------------------
// cukl_pkg: shared definitions for the compacted unique key list
// Field widths, operation codes, status codes and the default list depth.
// ---------------------------------------------------------------------------
`default_nettype none

package cukl_pkg;

  // Payload field widths
  localparam int KEY_W  = 27;
  localparam int OP_W   = 2;
  localparam int STAT_W = 4;
  localparam int POS_W  = 5;

  // Default number of list slots
  localparam int ENTRIES_DEF = 16;

  // Command codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LIST   = 2'd1,
    OP_DELETE = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  // Status codes of result items
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 4'd0,
    ST_DUPLICATE = 4'd1,
    ST_FULL      = 4'd2,
    ST_DELETED   = 4'd3,
    ST_NOT_FOUND = 4'd4,
    ST_UPDATED   = 4'd5,
    ST_TGT_EXIST = 4'd6,
    ST_LIST      = 4'd7,
    ST_ENTRY     = 4'd8,
    ST_EMPTY     = 4'd9
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/cukl_ram.sv
// ---------------------------------------------------------------------------
// cukl_ram: key storage
// One write port and one read port with registered read data. The read
// data holds while no read is issued. Contents are undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module cukl_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 27
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/cukl_ctrl.sv
// ---------------------------------------------------------------------------
// cukl_ctrl: command sequencer
// Walks the key storage one slot at a time with a single key comparator,
// compacts the list on delete, and streams status and listing items
// through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cukl_ctrl #(
  parameter int ENTRIES = 16,
  parameter int CNT_W   = 5,
  parameter int IDX_W   = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [cukl_pkg::OP_W-1:0]    in_operation,
  input  wire logic [cukl_pkg::KEY_W-1:0]   in_key,
  input  wire logic [cukl_pkg::KEY_W-1:0]   in_new_key,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [cukl_pkg::STAT_W-1:0]       out_status,
  output logic [cukl_pkg::POS_W-1:0]        out_position,
  output logic [cukl_pkg::KEY_W-1:0]        out_entry_value,
  output logic                              out_last,
  // storage port
  output logic                              ram_we,
  output logic [IDX_W-1:0]                  ram_waddr,
  output logic [cukl_pkg::KEY_W-1:0]        ram_wdata,
  output logic                              ram_re,
  output logic [IDX_W-1:0]                  ram_raddr,
  input  wire logic [cukl_pkg::KEY_W-1:0]   ram_rdata
);

  import cukl_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_CMP  = 9'b000000100,
    S_DEC  = 9'b000001000,
    S_SRD  = 9'b000010000,
    S_SWR  = 9'b000100000,
    S_STAT = 9'b001000000,
    S_LST  = 9'b010000000,
    S_LOUT = 9'b100000000
  } state_t;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  state_t               state_r,  state_nxt;
  op_t                  op_r,     op_nxt;
  logic [KEY_W-1:0]     key_r,    key_nxt;
  logic [KEY_W-1:0]     nkey_r,   nkey_nxt;
  logic                 pass_r,   pass_nxt;
  logic                 found_r,  found_nxt;
  logic [CNT_W-1:0]     idx_r,    idx_nxt;
  logic [CNT_W-1:0]     scan_r,   scan_nxt;
  logic [CNT_W-1:0]     cnt_r,    cnt_nxt;
  status_t              code_r,   code_nxt;
  logic                 last_r,   last_nxt;

  logic                 ovld_r,   ovld_nxt;
  status_t              ostat_r,  ostat_nxt;
  logic [POS_W-1:0]     opos_r,   opos_nxt;
  logic [KEY_W-1:0]     oval_r,   oval_nxt;
  logic                 olast_r,  olast_nxt;

  logic                 out_free;
  logic [CNT_W:0]       scan_p1;
  logic [KEY_W-1:0]     cmp_key;
  logic                 hit;
  logic                 list_end;

  assign out_free = !ovld_r || !out_stall;
  assign scan_p1  = {1'b0, scan_r} + 1'b1;
  assign list_end = (scan_p1 == {1'b0, cnt_r});

  // Shared comparator: old key on the first pass, new key on the second
  assign cmp_key = pass_r ? nkey_r : key_r;
  assign hit     = (ram_rdata == cmp_key);

  assign in_stall = (state_r != S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    nkey_nxt  = nkey_r;
    pass_nxt  = pass_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    scan_nxt  = scan_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    last_nxt  = last_r;

    ovld_nxt  = ovld_r && out_stall;
    ostat_nxt = ostat_r;
    opos_nxt  = opos_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;

    ram_we    = 1'b0;
    ram_waddr = scan_r[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = scan_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        // Capture a command transfer
        if (in_valid) begin
          op_nxt   = op_t'(in_operation);
          key_nxt  = in_key;
          nkey_nxt = in_new_key;
          pass_nxt = 1'b0;
          scan_nxt = '0;
          if (op_t'(in_operation) == OP_LIST) begin
            code_nxt  = ST_LIST;
            last_nxt  = 1'b0;
            state_nxt = S_STAT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        // Issue the next slot read, or end the search on a miss
        if (scan_r < cnt_r) begin
          ram_re    = 1'b1;
          state_nxt = S_CMP;
        end else begin
          found_nxt = 1'b0;
          state_nxt = S_DEC;
        end
      end

      S_CMP: begin
        if (hit) begin
          found_nxt = 1'b1;
          if (!pass_r) begin
            idx_nxt = scan_r;
          end
          state_nxt = S_DEC;
        end else begin
          scan_nxt  = scan_p1[CNT_W-1:0];
          state_nxt = S_RD;
        end
      end

      S_DEC: begin
        // Act on the search outcome
        state_nxt = S_STAT;
        last_nxt  = 1'b0;
        unique case (op_r)
          OP_INSERT: begin
            if (found_r) begin
              code_nxt = ST_DUPLICATE;
              last_nxt = 1'b1;
            end else if (cnt_r == FULL_CNT) begin
              code_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[IDX_W-1:0];
              ram_wdata = key_r;
              cnt_nxt   = cnt_r + 1'b1;
              code_nxt  = ST_INSERTED;
            end
          end
          OP_DELETE: begin
            if (found_r) begin
              scan_nxt  = idx_r;
              state_nxt = S_SRD;
            end else begin
              code_nxt = ST_NOT_FOUND;
              last_nxt = 1'b1;
            end
          end
          OP_UPDATE: begin
            if (!pass_r) begin
              if (found_r) begin
                pass_nxt  = 1'b1;
                scan_nxt  = '0;
                state_nxt = S_RD;
              end else begin
                code_nxt = ST_NOT_FOUND;
                last_nxt = 1'b1;
              end
            end else if (found_r) begin
              code_nxt = ST_TGT_EXIST;
              last_nxt = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = idx_r[IDX_W-1:0];
              ram_wdata = nkey_r;
              code_nxt  = ST_UPDATED;
            end
          end
          default: begin
            code_nxt = ST_LIST;
          end
        endcase
      end

      S_SRD: begin
        // Read the slot above, or finish the compaction
        if (scan_p1 < {1'b0, cnt_r}) begin
          ram_re    = 1'b1;
          ram_raddr = scan_p1[IDX_W-1:0];
          state_nxt = S_SWR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          code_nxt  = ST_DELETED;
          last_nxt  = 1'b0;
          state_nxt = S_STAT;
        end
      end

      S_SWR: begin
        // Move the entry down one slot
        ram_we    = 1'b1;
        ram_waddr = scan_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        scan_nxt  = scan_p1[CNT_W-1:0];
        state_nxt = S_SRD;
      end

      S_STAT: begin
        // Send the status item
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ostat_nxt = code_r;
          opos_nxt  = '0;
          oval_nxt  = '0;
          olast_nxt = last_r;
          scan_nxt  = '0;
          state_nxt = last_r ? S_IDLE : S_LST;
        end
      end

      S_LST: begin
        // Empty marker, or fetch the next entry to list
        if (cnt_r == '0) begin
          if (out_free) begin
            ovld_nxt  = 1'b1;
            ostat_nxt = ST_EMPTY;
            opos_nxt  = '0;
            oval_nxt  = '0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_LOUT;
        end
      end

      S_LOUT: begin
        // Send one listed entry
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ostat_nxt = ST_ENTRY;
          opos_nxt  = POS_W'(scan_p1);
          oval_nxt  = ram_rdata;
          olast_nxt = list_end;
          scan_nxt  = scan_p1[CNT_W-1:0];
          state_nxt = list_end ? S_IDLE : S_LST;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    nkey_r  <= nkey_nxt;
    pass_r  <= pass_nxt;
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
    scan_r  <= scan_nxt;
    code_r  <= code_nxt;
    last_r  <= last_nxt;
    ostat_r <= ostat_nxt;
    opos_r  <= opos_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_status      = ostat_r;
  assign out_position    = opos_r;
  assign out_entry_value = oval_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

FILE: rtl/compacted_unique_key_list.sv
// ---------------------------------------------------------------------------
// compacted_unique_key_list: packed list of unique keys
// Insert, delete with compaction, update and list commands over a simple dual
// port key store, each answered by a status item and optionally a listing.
//
//   channel | ports                                        | dir
//   --------+----------------------------------------------+-----
//   command | in_valid, in_stall, in_operation, in_key,    | in
//           | in_new_key                                   |
//   result  | out_valid, out_stall, out_status,            | out
//           | out_position, out_entry_value, out_last      |
//
// One command at a time; in_stall is high from its transfer until its last
// result is placed in the output register. The store has one read port,
// so a search reads and then compares one slot at a time, a delete moves
// each slot above the removed one down by a read and a write, and a
// listing reads each entry before sending it. An update that finds its
// key also searches for the new key; output stalls hold only result sends.
// Reset empties the list by zeroing the count; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module compacted_unique_key_list #(
  parameter int ENTRIES = cukl_pkg::ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [cukl_pkg::OP_W-1:0]    in_operation,
  input  wire logic [cukl_pkg::KEY_W-1:0]   in_key,
  input  wire logic [cukl_pkg::KEY_W-1:0]   in_new_key,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [cukl_pkg::STAT_W-1:0]       out_status,
  output logic [cukl_pkg::POS_W-1:0]        out_position,
  output logic [cukl_pkg::KEY_W-1:0]        out_entry_value,
  output logic                              out_last
);

  import cukl_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  // Command sequencer
  cukl_ctrl #(
    .ENTRIES (ENTRIES),
    .CNT_W   (CNT_W),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_new_key      (in_new_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_value (out_entry_value),
    .out_last        (out_last),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  // Key store
  cukl_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W),
    .DATA_W (KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for compacted_unique_key_list
// Drives insert, list, delete and update commands through the valid/stall
// command channel and checks every result transfer against a shadow copy of
// the key list kept here. A short scripted sequence walks empty, full and
// edge-key cases; a phased random sequence then fills and drains the list.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cukl_pkg::*;

  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 120;
  localparam int NO_SLOT      = -1;
  localparam int POOL_SIZE    = 24;
  localparam int PRINT_CAP    = 100;
  localparam longint LIMIT_NS = 10_000_000;

  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_TOP  = KEY_W'(99999999);

  // One expected result item
  typedef struct {
    status_t           status;
    logic [POS_W-1:0]  position;
    logic [KEY_W-1:0]  entry_value;
    logic              last;
  } reply_t;

  // Scripted command; typed > 0 gives the status items to expect directly
  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  nkey;
    logic [1:0]        typed;
    status_t           s0;
    status_t           s1;
  } script_row_t;

  localparam int SCRIPT_LEN = 26;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // empty list: listing, delete and update of a missing key
    '{OP_LIST,   27'd0,      27'd0,      2'd2, ST_LIST,      ST_EMPTY},
    '{OP_DELETE, 27'd5,      27'd0,      2'd1, ST_NOT_FOUND, ST_INSERTED},
    '{OP_UPDATE, 27'd5,      27'd6,      2'd1, ST_NOT_FOUND, ST_INSERTED},
    // smallest and all-ones keys, duplicate, update onto existing keys
    '{OP_INSERT, 27'd0,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd0,      27'd0,      2'd1, ST_DUPLICATE, ST_INSERTED},
    '{OP_INSERT, KEY_ONES,   27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_UPDATE, 27'd0,      27'd0,      2'd1, ST_TGT_EXIST, ST_INSERTED},
    '{OP_UPDATE, 27'd0,      KEY_ONES,   2'd1, ST_TGT_EXIST, ST_INSERTED},
    '{OP_UPDATE, 27'd0,      KEY_TOP,    2'd0, ST_INSERTED,  ST_INSERTED},
    // fill every slot
    '{OP_INSERT, 27'h5555555, 27'd0,     2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'h2AAAAAA, 27'd0,     2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd1,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd2,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd3,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd4,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd5,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd6,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd7,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd8,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd9,      27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd10,     27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd11,     27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd12,     27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    // full list: new key refused, present key still a duplicate
    '{OP_INSERT, 27'd77,     27'd0,      2'd0, ST_INSERTED,  ST_INSERTED},
    '{OP_INSERT, 27'd5,      27'd0,      2'd1, ST_DUPLICATE, ST_INSERTED},
    // remove slot one of a full list, shifting every entry
    '{OP_DELETE, KEY_TOP,    27'd0,      2'd0, ST_INSERTED,  ST_INSERTED}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation;
  logic [KEY_W-1:0]  in_key;
  logic [KEY_W-1:0]  in_new_key;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] out_status;
  logic [POS_W-1:0]  out_position;
  logic [KEY_W-1:0]  out_entry_value;
  logic              out_last;

  // Shadow key list and pending answers
  logic [KEY_W-1:0]  shadow_keys [ENTRIES];
  int                shadow_count = 0;
  reply_t            replies_due [$];
  bit                muted = 1'b0;
  bit                calm = 1'b0;

  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  int errors        = 0;
  int commands_sent = 0;
  int results_seen  = 0;
  int full_refusals = 0;
  int peak_fill     = 0;

  compacted_unique_key_list u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_new_key      (in_new_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_value (out_entry_value),
    .out_last        (out_last)
  );

  always #CLK_HALF clk = ~clk;

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Slot holding key k, or NO_SLOT
  function automatic int slot_of(input logic [KEY_W-1:0] k);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == k) return i;
    end
    return NO_SLOT;
  endfunction

  task automatic push_reply(input status_t s, input int pos,
                            input logic [KEY_W-1:0] v, input bit last);
    reply_t r;
    r.status      = s;
    r.position    = POS_W'(pos);
    r.entry_value = v;
    r.last        = last;
    if (!muted) replies_due.push_back(r);
  endtask

  task automatic push_listing();
    if (shadow_count == 0) begin
      push_reply(ST_EMPTY, 0, '0, 1'b1);
    end else begin
      for (int i = 0; i < shadow_count; i++) begin
        push_reply(ST_ENTRY, i + 1, shadow_keys[i], (i + 1) == shadow_count);
      end
    end
  endtask

  // Advance the shadow list by one command and queue its answers
  task automatic answer_command(input op_t op, input logic [KEY_W-1:0] k,
                                input logic [KEY_W-1:0] nk);
    int at;
    at = slot_of(k);
    case (op)
      OP_INSERT: begin
        if (at != NO_SLOT) begin
          push_reply(ST_DUPLICATE, 0, '0, 1'b1);
        end else begin
          if (shadow_count >= ENTRIES) begin
            full_refusals++;
            push_reply(ST_FULL, 0, '0, 1'b0);
          end else begin
            shadow_keys[shadow_count] = k;
            shadow_count++;
            push_reply(ST_INSERTED, 0, '0, 1'b0);
          end
          push_listing();
        end
      end
      OP_LIST: begin
        push_reply(ST_LIST, 0, '0, 1'b0);
        push_listing();
      end
      OP_DELETE: begin
        if (at == NO_SLOT) begin
          push_reply(ST_NOT_FOUND, 0, '0, 1'b1);
        end else begin
          // close the gap left by the removed key
          for (int i = at; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
          end
          shadow_count--;
          push_reply(ST_DELETED, 0, '0, 1'b0);
          push_listing();
        end
      end
      default: begin
        if (at == NO_SLOT) begin
          push_reply(ST_NOT_FOUND, 0, '0, 1'b1);
        end else if (slot_of(nk) != NO_SLOT) begin
          push_reply(ST_TGT_EXIST, 0, '0, 1'b1);
        end else begin
          shadow_keys[at] = nk;
          push_reply(ST_UPDATED, 0, '0, 1'b0);
          push_listing();
        end
      end
    endcase
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endtask

  // Mostly short gaps, a few long ones, none during calm stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Key from the stored list with the given percentage, else pool or random
  function automatic logic [KEY_W-1:0] pick_key(input int stored_pct);
    int r;
    logic [KEY_W-1:0] any;
    r   = $urandom_range(0, 99);
    any = KEY_W'($urandom());
    if (shadow_count > 0 && r < stored_pct) begin
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    end
    if (r < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return any;
  endfunction

  // Offer one command after a gap, wait for its transfer, then predict
  task automatic issue(input op_t op, input logic [KEY_W-1:0] k,
                       input logic [KEY_W-1:0] nk, input int gap,
                       input int typed, input status_t s0, input status_t s1);
    if (gap > 0) begin
      in_valid     <= 1'b0;
      in_operation <= OP_W'($urandom());
      in_key       <= KEY_W'($urandom());
      in_new_key   <= KEY_W'($urandom());
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= k;
    in_new_key   <= nk;
    do @(posedge clk); while (in_stall);
    commands_sent++;
    muted = (typed > 0);
    answer_command(op, k, nk);
    muted = 1'b0;
    for (int j = 0; j < typed; j++) begin
      push_reply((j == 0) ? s0 : s1, 0, '0, j == typed - 1);
    end
  endtask

  // Check each result transfer against the oldest pending answer
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (replies_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d position %0d value %0d",
                                out_status, out_position, out_entry_value));
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status)
          flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  results_seen, out_status, want.status));
        if (out_position !== want.position)
          flag_mismatch($sformatf("result %0d position %0d, expected %0d",
                                  results_seen, out_position, want.position));
        if (out_entry_value !== want.entry_value)
          flag_mismatch($sformatf("result %0d value %0d, expected %0d",
                                  results_seen, out_entry_value, want.entry_value));
        if (out_last !== want.last)
          flag_mismatch($sformatf("result %0d last %0b, expected %0b",
                                  results_seen, out_last, want.last));
      end
    end
  end

  // Result-side backpressure
  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = idle_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  end

  // Stimulus: reset, scripted commands, phased random commands
  initial begin
    int r;
    int phase;
    op_t op;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] nk;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_INSERT;
    in_key       <= '0;
    in_new_key   <= '0;

    // small key pool so inserts collide and deletes hit
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    key_pool[2] = KEY_TOP;
    key_pool[3] = 27'h4000000;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom_range(0, 99999999));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      issue(SCRIPT[i].op, SCRIPT[i].key, SCRIPT[i].nkey, idle_len(),
            SCRIPT[i].typed, SCRIPT[i].s0, SCRIPT[i].s1);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm  = (n % 60) >= 48;
      phase = (n / 45) % 3;
      r     = $urandom_range(0, 99);
      // fill phase, drain phase, mixed phase
      case (phase)
        0:       op = (r < 60) ? OP_INSERT : (r < 72) ? OP_DELETE :
                      (r < 87) ? OP_UPDATE : OP_LIST;
        1:       op = (r < 15) ? OP_INSERT : (r < 65) ? OP_DELETE :
                      (r < 85) ? OP_UPDATE : OP_LIST;
        default: op = (r < 32) ? OP_INSERT : (r < 57) ? OP_DELETE :
                      (r < 85) ? OP_UPDATE : OP_LIST;
      endcase
      case (op)
        OP_INSERT: k = pick_key(20);
        OP_DELETE: k = pick_key(70);
        OP_UPDATE: k = pick_key(75);
        default:   k = pick_key(0);
      endcase
      r = $urandom_range(0, 99);
      if (r < 25) nk = pick_key(100);
      else if (r < 35) nk = k;
      else nk = pick_key(0);
      issue(op, k, nk, idle_len(), 0, ST_INSERTED, ST_INSERTED);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain outstanding answers, then let the block settle
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d scripted) and %0d result transfers",
             commands_sent, SCRIPT_LEN, results_seen);
    $display("Inserts refused on a full list: %0d, deepest fill %0d of %0d slots",
             full_refusals, peak_fill, ENTRIES);
    if (errors == 0) begin
      $display("PASS compacted_unique_key_list");
    end else begin
      $display("FAIL compacted_unique_key_list");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_NS);
    $display("FAIL compacted_unique_key_list");
    $finish;
  end

endmodule

`default_nettype wire
